// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files of the quaternion converter.
// Depends on nothing; included by rmq_back, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define RMQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define RMQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/rmq_pkg.sv =====
// Shared constants and types of the rotation matrix to quaternion converter.
// Depends on nothing; used by every module of the block.
package rmq_pkg;

   localparam int DATA_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int QUEUE_DEPTH    = 4;

   // Branch codes as they appear on the result port.
   typedef enum logic [1:0] {
      BR_W = 2'd0,
      BR_X = 2'd1,
      BR_Y = 2'd2,
      BR_Z = 2'd3
   } branch_type;

   function automatic int max2(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Signed width that holds the trace, the constant one and any radicand.
   function automatic int rad_sw(input int dw, input int fb);
      return max2(dw, fb + 1) + 3;
   endfunction

   // Number of root bits produced for a radicand scaled by 2^fb.
   function automatic int root_w(input int dw, input int fb);
      return (rad_sw(dw, fb) - 1 + fb + 1) / 2;
   endfunction

endpackage

// ===== hdl/rmq_front.sv =====
// Front end: picks the branch, forms the radicand and the three numerators.
// Depends on rmq_pkg.
module rmq_front #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
   localparam int SW        = rmq_pkg::rad_sw(DATA_WIDTH, FRAC_BITS),
   localparam int RW        = SW - 1,
   localparam int MW        = DATA_WIDTH + 1,
   localparam int ENTRY_W   = 2 + RW + 4 + 4 * MW
) (
   input  logic [DATA_WIDTH-1:0] rot_00,
   input  logic [DATA_WIDTH-1:0] rot_01,
   input  logic [DATA_WIDTH-1:0] rot_02,
   input  logic [DATA_WIDTH-1:0] rot_10,
   input  logic [DATA_WIDTH-1:0] rot_11,
   input  logic [DATA_WIDTH-1:0] rot_12,
   input  logic [DATA_WIDTH-1:0] rot_20,
   input  logic [DATA_WIDTH-1:0] rot_21,
   input  logic [DATA_WIDTH-1:0] rot_22,
   output logic [ENTRY_W-1:0]    entry
);

   logic signed [SW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
   logic signed [SW-1:0] one_fx, trace, rad;
   logic signed [SW-1:0] num [4];
   logic [RW-1:0]        radicand;
   logic [3:0]           neg;
   logic [MW-1:0]        mag [4];
   rmq_pkg::branch_type  branch;

   assign e00 = SW'($signed(rot_00));
   assign e01 = SW'($signed(rot_01));
   assign e02 = SW'($signed(rot_02));
   assign e10 = SW'($signed(rot_10));
   assign e11 = SW'($signed(rot_11));
   assign e12 = SW'($signed(rot_12));
   assign e20 = SW'($signed(rot_20));
   assign e21 = SW'($signed(rot_21));
   assign e22 = SW'($signed(rot_22));
   assign one_fx = SW'(1) <<< FRAC_BITS;
   assign trace  = e00 + e11 + e22;

   // Lanes 0..3 are x, y, z, w; the branch's own lane carries a zero numerator.
   always_comb begin
      num[0] = '0;
      num[1] = '0;
      num[2] = '0;
      num[3] = '0;
      if (trace > 0) begin
         branch = rmq_pkg::BR_W;
         rad    = trace + one_fx;
         num[0] = e21 - e12;
         num[1] = e02 - e20;
         num[2] = e10 - e01;
      end else if (e00 > e11 && e00 > e22) begin
         branch = rmq_pkg::BR_X;
         rad    = one_fx + e00 - e11 - e22;
         num[3] = e21 - e12;
         num[1] = e01 + e10;
         num[2] = e02 + e20;
      end else if (e11 > e22) begin
         branch = rmq_pkg::BR_Y;
         rad    = one_fx + e11 - e00 - e22;
         num[3] = e02 - e20;
         num[0] = e01 + e10;
         num[2] = e12 + e21;
      end else begin
         branch = rmq_pkg::BR_Z;
         rad    = one_fx + e22 - e00 - e11;
         num[3] = e10 - e01;
         num[0] = e02 + e20;
         num[1] = e12 + e21;
      end
   end

   // A radicand that is not positive becomes zero, which yields a zero root.
   assign radicand = (rad > 0) ? rad[RW-1:0] : '0;

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         neg[l] = num[l][SW-1];
         mag[l] = neg[l] ? MW'(-num[l]) : MW'(num[l]);
      end
   end

   assign entry = {branch, radicand, neg, mag[3], mag[2], mag[1], mag[0]};

endmodule

// ===== hdl/rmq_queue.sv =====
// Short first-in first-out queue between the front end and the back end.
// Depends on rmq_pkg for its depth.
module rmq_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rmq_pkg::QUEUE_DEPTH,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== hdl/rmq_back.sv =====
// Back end: pipelined square root, pipelined dividers, saturation, result register.
// Depends on rmq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rmq_back #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
   localparam int SW        = rmq_pkg::rad_sw(DATA_WIDTH, FRAC_BITS),
   localparam int RW        = SW - 1,
   localparam int MW        = DATA_WIDTH + 1,
   localparam int ENTRY_W   = 2 + RW + 4 + 4 * MW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  logic [ENTRY_W-1:0]    q_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_quat_x,
   output logic [DATA_WIDTH-1:0] rsp_quat_y,
   output logic [DATA_WIDTH-1:0] rsp_quat_z,
   output logic [DATA_WIDTH-1:0] rsp_quat_w,
   output logic [1:0]            rsp_branch_taken,
   output logic                  rsp_degenerate
);

   localparam int W    = DATA_WIDTH;
   localparam int SQW  = rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS);
   localparam int SCW  = 2 * SQW;
   localparam int SIDE = 2 + 4 + 4 * MW;
   localparam int SSW  = SQW + 1;
   localparam int CW   = rmq_pkg::max2(MW + FRAC_BITS, SSW + W) + 1;
   localparam int OW   = rmq_pkg::max2(SQW, W) + 1;

   logic adv;
   logic rsp_valid_ff;

   // One pipeline; every stage moves together when the result register can take a word.
   assign adv     = !rsp_valid_ff || rsp_ready;
   assign q_ready = adv;

   // Square root stages: one root bit per stage.
   logic [SCW-1:0]  sq_scaled_ff [SQW];
   logic [SQW+1:0]  sq_rem_ff    [SQW];
   logic [SQW-1:0]  sq_root_ff   [SQW];
   logic [SIDE-1:0] sq_side_ff   [SQW];
   logic [SQW-1:0]  sq_valid_ff;

   for (genvar t = 0; t < SQW; t++) begin : g_sqrt
      logic [SCW-1:0]  scaled_src;
      logic [SQW+1:0]  rem_src, rem_cat, trial;
      logic [SQW-1:0]  root_src;
      logic [SIDE-1:0] side_src;
      logic            valid_src;
      logic [SQW+1:0]  rem_in;
      logic [SQW-1:0]  root_in;

      if (t == 0) begin : g_first
         assign scaled_src = SCW'(q_data[ENTRY_W-3 -: RW]) << FRAC_BITS;
         assign rem_src    = '0;
         assign root_src   = '0;
         assign side_src   = {q_data[ENTRY_W-1 -: 2], q_data[SIDE-3:0]};
         assign valid_src  = q_valid;
      end else begin : g_next
         assign scaled_src = sq_scaled_ff[t-1];
         assign rem_src    = sq_rem_ff[t-1];
         assign root_src   = sq_root_ff[t-1];
         assign side_src   = sq_side_ff[t-1];
         assign valid_src  = sq_valid_ff[t-1];
      end

      assign rem_cat = {rem_src[SQW-1:0], scaled_src[2*(SQW-1-t)+1 -: 2]};
      assign trial   = {root_src, 2'b01};

      always_comb begin
         if (rem_cat >= trial) begin
            rem_in  = rem_cat - trial;
            root_in = {root_src[SQW-2:0], 1'b1};
         end else begin
            rem_in  = rem_cat;
            root_in = {root_src[SQW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[t] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[t] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_scaled_ff[t] <= scaled_src;
            sq_rem_ff[t]    <= rem_in;
            sq_root_ff[t]   <= root_in;
            sq_side_ff[t]   <= side_src;
         end
      end
   end

   // Divider stages: stage zero checks for quotient overflow, then one bit per stage.
   logic [CW-1:0]  dv_rem_ff  [W+1][4];
   logic [W-1:0]   dv_q_ff    [W+1][4];
   logic [3:0]     dv_ovf_ff  [W+1];
   logic [3:0]     dv_neg_ff  [W+1];
   logic [1:0]     dv_br_ff   [W+1];
   logic [SQW-1:0] dv_root_ff [W+1];
   logic [W:0]     dv_valid_ff;

   logic [SQW-1:0]  root_last;
   logic [SIDE-1:0] side_last;
   logic [SSW-1:0]  s_last;

   assign root_last = sq_root_ff[SQW-1];
   assign side_last = sq_side_ff[SQW-1];
   assign s_last    = {root_last, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_valid_ff[0] <= sq_valid_ff[SQW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 4; l++) begin
            dv_rem_ff[0][l] <= CW'(side_last[l*MW +: MW]) << FRAC_BITS;
            dv_q_ff[0][l]   <= '0;
            dv_ovf_ff[0][l] <= (CW'(side_last[l*MW +: MW]) << FRAC_BITS)
                               >= (CW'(s_last) << W);
         end
         dv_neg_ff[0]  <= side_last[4*MW +: 4];
         dv_br_ff[0]   <= side_last[SIDE-1 -: 2];
         dv_root_ff[0] <= root_last;
      end
   end

   for (genvar t = 1; t <= W; t++) begin : g_div
      logic [CW-1:0] sub;

      assign sub = CW'({dv_root_ff[t-1], 1'b0}) << (W - t);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[t] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[t] <= dv_valid_ff[t-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int l = 0; l < 4; l++) begin
               if (dv_rem_ff[t-1][l] >= sub) begin
                  dv_rem_ff[t][l] <= dv_rem_ff[t-1][l] - sub;
                  dv_q_ff[t][l]   <= dv_q_ff[t-1][l] | (W'(1) << (W - t));
               end else begin
                  dv_rem_ff[t][l] <= dv_rem_ff[t-1][l];
                  dv_q_ff[t][l]   <= dv_q_ff[t-1][l];
               end
            end
            dv_ovf_ff[t]  <= dv_ovf_ff[t-1];
            dv_neg_ff[t]  <= dv_neg_ff[t-1];
            dv_br_ff[t]   <= dv_br_ff[t-1];
            dv_root_ff[t] <= dv_root_ff[t-1];
         end
      end
   end

   // Sign, saturation and the branch's own component.
   localparam logic [W-1:0] HI  = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] LO  = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0]  comp [4];
   logic [OW-1:0] own_wide;
   logic [W-1:0]  own_val;
   logic [1:0]    own_lane;
   logic          degen;

   assign own_wide = OW'(dv_root_ff[W] >> 1);
   assign own_val  = (own_wide > OW'(HI)) ? HI : own_wide[W-1:0];
   assign degen    = (dv_root_ff[W] == '0);

   always_comb begin
      unique case (rmq_pkg::branch_type'(dv_br_ff[W]))
         rmq_pkg::BR_W: own_lane = 2'd3;
         rmq_pkg::BR_X: own_lane = 2'd0;
         rmq_pkg::BR_Y: own_lane = 2'd1;
         rmq_pkg::BR_Z: own_lane = 2'd2;
         default:       own_lane = 2'd3;
      endcase
   end

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (degen) begin
            comp[l] = '0;
         end else if (own_lane == 2'(l)) begin
            comp[l] = own_val;
         end else if (!dv_neg_ff[W][l]) begin
            comp[l] = (dv_ovf_ff[W][l] || dv_q_ff[W][l][W-1]) ? HI : dv_q_ff[W][l];
         end else if (dv_ovf_ff[W][l] || dv_q_ff[W][l] > LO) begin
            comp[l] = LO;
         end else begin
            comp[l] = ~dv_q_ff[W][l] + 1'b1;
         end
      end
   end

   logic [W-1:0] quat_ff [4];
   logic [1:0]   branch_ff;
   logic         degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 4; l++) quat_ff[l] <= comp[l];
         branch_ff <= dv_br_ff[W];
         degen_ff  <= degen;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_quat_x       = quat_ff[0];
   assign rsp_quat_y       = quat_ff[1];
   assign rsp_quat_z       = quat_ff[2];
   assign rsp_quat_w       = quat_ff[3];
   assign rsp_branch_taken = branch_ff;
   assign rsp_degenerate   = degen_ff;

   `RMQ_ASSERT(a_degen_zero, clock, reset, !(rsp_valid_ff && degen_ff) || (quat_ff[0] == '0 && quat_ff[1] == '0 && quat_ff[2] == '0 && quat_ff[3] == '0))
   `RMQ_ASSERT_NEXT(a_hold_pipe, clock, reset, !adv, $stable(dv_valid_ff) && $stable(sq_valid_ff))
   `RMQ_ASSERT(a_w_nonneg, clock, reset, !(rsp_valid_ff && branch_ff == rmq_pkg::BR_W) || !quat_ff[3][W-1])

endmodule

// ===== hdl/rotation_matrix_to_quaternion_core.sv =====
// Rotation matrix to quaternion converter, four-branch trace method, Q format
// set by DATA_WIDTH and FRAC_BITS. Takes one matrix word per cycle and returns
// one quaternion word per cycle once full, while rsp_ready does not stall it.
// A matrix word passes the queue, then the square root pipeline, which yields
// one root bit per stage for R root bits (21 at the default Q7.16 in 24 bits),
// then one stage that checks the quotients for overflow, the divider pipeline,
// which yields one quotient bit per stage for W = DATA_WIDTH bits, and last a
// register that holds the result. A four-word queue sits between the classifying
// front end and that pipeline; it holds matrix words while the result side stalls.
// Depends on rmq_pkg, rmq_front, rmq_queue and rmq_back.
module rotation_matrix_to_quaternion_core #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DATA_WIDTH-1:0] req_rot_00,
   input  logic [DATA_WIDTH-1:0] req_rot_01,
   input  logic [DATA_WIDTH-1:0] req_rot_02,
   input  logic [DATA_WIDTH-1:0] req_rot_10,
   input  logic [DATA_WIDTH-1:0] req_rot_11,
   input  logic [DATA_WIDTH-1:0] req_rot_12,
   input  logic [DATA_WIDTH-1:0] req_rot_20,
   input  logic [DATA_WIDTH-1:0] req_rot_21,
   input  logic [DATA_WIDTH-1:0] req_rot_22,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_quat_x,
   output logic [DATA_WIDTH-1:0] rsp_quat_y,
   output logic [DATA_WIDTH-1:0] rsp_quat_z,
   output logic [DATA_WIDTH-1:0] rsp_quat_w,
   output logic [1:0]            rsp_branch_taken,
   output logic                  rsp_degenerate
);

   localparam int SW      = rmq_pkg::rad_sw(DATA_WIDTH, FRAC_BITS);
   localparam int ENTRY_W = 2 + (SW - 1) + 4 + 4 * (DATA_WIDTH + 1);

   logic [ENTRY_W-1:0] front_entry, q_data;
   logic               q_valid, q_ready;

   rmq_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
      .rot_00 (req_rot_00),
      .rot_01 (req_rot_01),
      .rot_02 (req_rot_02),
      .rot_10 (req_rot_10),
      .rot_11 (req_rot_11),
      .rot_12 (req_rot_12),
      .rot_20 (req_rot_20),
      .rot_21 (req_rot_21),
      .rot_22 (req_rot_22),
      .entry  (front_entry)
   );

   rmq_queue #(.WIDTH(ENTRY_W), .DEPTH(rmq_pkg::QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (front_entry),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   rmq_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_data           (q_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_quat_x       (rsp_quat_x),
      .rsp_quat_y       (rsp_quat_y),
      .rsp_quat_z       (rsp_quat_z),
      .rsp_quat_w       (rsp_quat_w),
      .rsp_branch_taken (rsp_branch_taken),
      .rsp_degenerate   (rsp_degenerate)
   );

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for rotation_matrix_to_quaternion_core: directed matrices, then random ones,
// with random idling on both channels, each result word checked against a local predictor or a typed value.
// Depends on rmq_pkg and the core RTL.
`timescale 1ns / 1ps
module tb;

   localparam int DW = rmq_pkg::DATA_WIDTH_DEF;
   localparam int FB = rmq_pkg::FRAC_BITS_DEF;
   localparam longint ONE = 64'sd1 <<< FB;
   localparam longint FX_MAX = (64'sd1 <<< (DW - 1)) - 1;
   localparam longint FX_MIN = -(64'sd1 <<< (DW - 1));
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 120;
   localparam int N_RANDOM = 1800;

   typedef logic [DW-1:0] fx_type;

   typedef struct {
      fx_type              q[4];   // x, y, z, w
      rmq_pkg::branch_type branch;
      logic                degen;
   } quat_type;

   typedef struct {
      fx_type   rot[9];
      bit       typed;
      quat_type want;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic rsp_ready = 0;
   fx_type rot_in[9];
   logic req_ready, rsp_valid, rsp_degenerate;
   logic [1:0] rsp_branch_taken;
   fx_type rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;

   quat_type pending_quats[$];
   int    errors = 0;
   int    cycle_count = 0;
   bit    rsp_idle_on = 1;

   always #2 clock = ~clock;

   rotation_matrix_to_quaternion_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_rot_00(rot_in[0]), .req_rot_01(rot_in[1]), .req_rot_02(rot_in[2]),
      .req_rot_10(rot_in[3]), .req_rot_11(rot_in[4]), .req_rot_12(rot_in[5]),
      .req_rot_20(rot_in[6]), .req_rot_21(rot_in[7]), .req_rot_22(rot_in[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_quat_x(rsp_quat_x), .rsp_quat_y(rsp_quat_y),
      .rsp_quat_z(rsp_quat_z), .rsp_quat_w(rsp_quat_w),
      .rsp_branch_taken(rsp_branch_taken), .rsp_degenerate(rsp_degenerate)
   );

   function automatic longint sat_fx(input longint v);
      if (v > FX_MAX) return FX_MAX;
      if (v < FX_MIN) return FX_MIN;
      return v;
   endfunction

   // Floor of the square root, one result bit at a time.
   function automatic longint isqrt(input longint v);
      longint r;
      longint b;
      r = 0;
      for (int k = 31; k >= 0; k--) begin
         b = r | (64'sd1 <<< k);
         if (b * b <= v) r = b;
      end
      return r;
   endfunction

   function automatic longint frac_div(input longint num, input longint s);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag <<< FB) / s;
      if (q > (64'sd1 <<< DW)) q = 64'sd1 <<< DW;
      return sat_fx((num < 0) ? -q : q);
   endfunction

   function automatic quat_type quat_from_matrix(input fx_type rot[9]);
      longint m[9];
      longint num[4];
      longint tr, rad, root;
      int own;
      quat_type res;
      for (int j = 0; j < 9; j++) m[j] = longint'(signed'(rot[j]));
      tr = m[0] + m[4] + m[8];
      if (tr > 0) begin
         res.branch = rmq_pkg::BR_W; own = 3; rad = tr + ONE;
         num[0] = m[7] - m[5]; num[1] = m[2] - m[6]; num[2] = m[3] - m[1];
      end else if (m[0] > m[4] && m[0] > m[8]) begin
         res.branch = rmq_pkg::BR_X; own = 0; rad = ONE + m[0] - m[4] - m[8];
         num[3] = m[7] - m[5]; num[1] = m[1] + m[3]; num[2] = m[2] + m[6];
      end else if (m[4] > m[8]) begin
         res.branch = rmq_pkg::BR_Y; own = 1; rad = ONE + m[4] - m[0] - m[8];
         num[3] = m[2] - m[6]; num[0] = m[1] + m[3]; num[2] = m[5] + m[7];
      end else begin
         res.branch = rmq_pkg::BR_Z; own = 2; rad = ONE + m[8] - m[0] - m[4];
         num[3] = m[3] - m[1]; num[0] = m[2] + m[6]; num[1] = m[5] + m[7];
      end
      num[own] = 0;
      for (int j = 0; j < 4; j++) res.q[j] = '0;
      res.degen = 1;
      if (rad > 0) begin
         root = isqrt(rad <<< FB);
         if (root != 0) begin
            res.degen = 0;
            for (int j = 0; j < 4; j++)
               res.q[j] = (j == own) ? fx_type'(sat_fx(root >>> 1))
                                     : fx_type'(frac_div(num[j], root <<< 1));
         end
      end
      return res;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
   endtask

   function automatic int idle_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result checker.
   always @(posedge clock) begin
      quat_type w;
      fx_type got[4];
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_quats.size() == 0) begin
            report("unexpected word", 0, 0);
         end else begin
            w = pending_quats.pop_front();
            got[0] = rsp_quat_x; got[1] = rsp_quat_y;
            got[2] = rsp_quat_z; got[3] = rsp_quat_w;
            for (int j = 0; j < 4; j++)
               if (got[j] !== w.q[j]) report($sformatf("quat[%0d]", j), got[j], w.q[j]);
            if (rsp_branch_taken !== w.branch)
               report("branch_taken", rsp_branch_taken, w.branch);
            if (rsp_degenerate !== w.degen) report("degenerate", rsp_degenerate, w.degen);
         end
      end
   end

   // Receiver stalls.
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = rsp_idle_on ? idle_len() : 0;
         if (n > 0) begin
            rsp_ready <= 0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1;
         @(negedge clock);
      end
   end

   task automatic send_matrix(input fx_type rot[9], input bit idle_on);
      int n;
      n = idle_on ? idle_len() : 0;
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
      for (int j = 0; j < 9; j++) rot_in[j] <= rot[j];
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      pending_quats = {pending_quats, quat_from_matrix(rot)};
      @(negedge clock);
   endtask

   function automatic fx_type rand_fx(input int kind);
      case (kind)
         0: return fx_type'($urandom);
         1: return fx_type'(longint'($urandom_range(0, 4 * ONE)) - 2 * ONE);
         default: return fx_type'(longint'($urandom_range(0, 2 * ONE)) - ONE);
      endcase
   endfunction

   row_type directed[$];

   function automatic row_type mk(input longint d0, d4, d8, off, bit typed = 0,
                                  longint qx = 0, qy = 0, qz = 0, qw = 0,
                                  rmq_pkg::branch_type br = rmq_pkg::BR_W,
                                  logic dg = 0);
      row_type r;
      for (int j = 0; j < 9; j++)
         r.rot[j] = fx_type'(off * (j + 1) * ((j % 2) ? -1 : 1));
      r.rot[0] = fx_type'(d0); r.rot[4] = fx_type'(d4); r.rot[8] = fx_type'(d8);
      r.typed = typed;
      r.want.q[0] = fx_type'(qx); r.want.q[1] = fx_type'(qy);
      r.want.q[2] = fx_type'(qz); r.want.q[3] = fx_type'(qw);
      r.want.branch = br; r.want.degen = dg;
      return r;
   endfunction

   initial begin
      fx_type rot[9];
      row_type r;
      int kind, br;
      bit idle_on;
      for (int j = 0; j < 9; j++) rot_in[j] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Identity and the zero matrix have results that are easy to work out.
      directed = {directed, mk(ONE, ONE, ONE, 0, 1, 0, 0, 0, ONE, rmq_pkg::BR_W, 0)};
      directed = {directed, mk(0, 0, 0, 0, 1, 0, 0, ONE / 2, 0, rmq_pkg::BR_Z, 0)};
      directed = {directed, mk(ONE, -ONE, -ONE, 0)};            // x largest
      directed = {directed, mk(-ONE, ONE, -ONE, 0)};            // y largest
      directed = {directed, mk(-ONE, -ONE, ONE, 0)};            // z largest
      directed = {directed, mk(-ONE, -ONE, -ONE, 0)};           // ties fall through to z
      directed = {directed, mk(0, 0, -ONE, 300)};               // x and y tie, y wins
      directed = {directed, mk(FX_MAX, FX_MAX, FX_MAX, 0)};
      directed = {directed, mk(FX_MIN, FX_MIN, FX_MIN, FX_MAX)};
      directed = {directed, mk(FX_MIN, FX_MIN, FX_MIN, FX_MIN)};
      directed = {directed, mk(1, 0, -1, FX_MAX)};              // zero trace, x largest
      directed = {directed, mk(FX_MAX, FX_MIN, FX_MIN, FX_MAX)}; // extreme diagonal, x largest
      directed = {directed, mk(-3 * ONE, -3 * ONE, -ONE, FX_MIN)};
      directed = {directed, mk(-ONE, -ONE, -ONE, 1)};
      directed = {directed, mk(FX_MIN, FX_MAX, FX_MIN, 12345)};
      foreach (directed[i]) begin
         r = directed[i];
         send_matrix(r.rot, 0);
         if (r.typed) begin
            // Overwrite the prediction with the value typed into the table.
            pending_quats[pending_quats.size() - 1] = r.want;
         end
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         idle_on = ((i / 150) % 4) != 1;
         rsp_idle_on = ((i / 200) % 3) != 2;
         if (i == N_RANDOM / 2) begin
            req_valid <= 0;
            while (pending_quats.size() != 0) @(negedge clock);
         end
         kind = $urandom_range(0, 9);
         if (kind < 2) begin
            for (int j = 0; j < 9; j++) rot[j] = rand_fx(0);
         end else begin
            // Near-rotation that leans to a positive trace or to one dominant diagonal entry; kind 9 copies a tie.
            for (int j = 0; j < 9; j++) rot[j] = rand_fx(kind < 6 ? 2 : 1);
            br = $urandom_range(0, 3);
            if (br == 0) begin
               rot[0] = fx_type'($urandom_range(0, ONE));
               rot[4] = fx_type'($urandom_range(0, ONE));
            end else begin
               for (int d = 0; d < 3; d++)
                  rot[d * 4] = fx_type'(-longint'($urandom_range(0, ONE)));
               rot[(br - 1) * 4] = (kind == 9) ? rot[((br) % 3) * 4]
                                               : fx_type'($urandom_range(0, ONE));
            end
         end
         send_matrix(rot, idle_on);
      end
      req_valid <= 0;

      while (pending_quats.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
